### hdl/sfip_pkg.sv
// package: constants, codes and types for the spi flash image programmer
package sfip_pkg;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_PAGES = 16;
  localparam int MAX_RESULTS  = 10;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int OFS_W      = PAGE_SHIFT;
  localparam int SEC_W      = (SECTOR_PAGES > 1) ? $clog2(SECTOR_PAGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

  localparam int VIDEO_OFFSET    = 'h4D;
  localparam int SCANLINE_OFFSET = 'h4E;

  localparam logic [15:0] PATCH_PAGE_RESET = 16'd112;

  localparam logic [7:0] OP_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] OP_SECTOR_ERASE = 8'h20;
  localparam logic [7:0] OP_PAGE_PROGRAM = 8'h02;
  localparam logic [7:0] OP_READ_STATUS  = 8'h05;

  typedef enum logic [1:0] {
    REG_PATCH_PAGE     = 2'd0,
    REG_VIDEO_OPTION   = 2'd1,
    REG_SCANLINE_OPTION = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ACT_DATA   = 2'd0,
    ACT_STATUS = 2'd1,
    ACT_END    = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    KIND_SEND    = 3'd0,
    KIND_READ    = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

endpackage

### hdl/spi_flash_image_programmer_top.sv
// top level: spi nor page program sequencer driven by an image and status byte stream
//
// channel  direction  tdata              tuser        tlast
// s_*      in         payload[7:0]       action[1:0]  -
// m_*      out        spi_byte[7:0]      kind[2:0]    last
// cfg_*    in         cfg_data[15:0]     cfg_index    -
//
// each input request is decoded in the cycle it is accepted into a list of 1 to 9
// results; results leave one per cycle from a shift register while m_tready is high,
// so a request holds the output for as many transfers as results it causes
// a one-list skid register takes one more request while the output list drains,
// then the input stalls until that list has moved on
// synchronous reset clears phase, counters, flags and both list stages
module spi_flash_image_programmer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // payload[7:0]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // spi_byte[7:0]
  output logic [2:0]  m_tuser,   // kind[2:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sfip_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_PRE, PH_PAGE, PH_POST} phase_t;

  logic [15:0] patch_page;
  logic [7:0]  video_option_value;
  logic [7:0]  scanline_option_value;

  phase_t           phase, phase_next;
  logic [15:0]      page_count, page_count_next;
  logic [SEC_W-1:0] sector_pos, sector_pos_next;
  logic [OFS_W-1:0] offset_in_page, offset_in_page_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             finished, finished_next;

  kind_t      l_kind [MAX_RESULTS];
  logic [7:0] l_byte [MAX_RESULTS];
  logic [CNT_W-1:0] n;

  kind_t      a_kind [MAX_RESULTS];
  logic [7:0] a_byte [MAX_RESULTS];
  logic [CNT_W-1:0] a_cnt;
  logic       a_valid;

  kind_t      b_kind [MAX_RESULTS];
  logic [7:0] b_byte [MAX_RESULTS];
  logic [CNT_W-1:0] b_rem;

  logic       s_fire, m_fire, b_free;
  logic [39:0] addr_wide;
  logic [23:0] addr;
  logic [7:0]  pay_patched;
  logic        busy;

  assign s_fire = s_tvalid && s_tready;
  assign m_fire = m_tvalid && m_tready;
  assign b_free = (b_rem == '0) || ((b_rem == CNT_W'(1)) && m_tready);
  assign s_tready = !a_valid;
  assign cfg_ready = 1'b1;

  assign m_tvalid = (b_rem != '0);
  assign m_tdata  = b_byte[0];
  assign m_tuser  = b_kind[0];
  assign m_tlast  = (b_rem == CNT_W'(1));

  assign addr_wide = {24'b0, page_count} << PAGE_SHIFT;
  assign addr      = addr_wide[23:0];
  assign busy      = s_tdata[0];

  always_comb begin
    pay_patched = s_tdata;
    if (page_count == patch_page) begin
      if (32'(offset_in_page) == 32'(VIDEO_OFFSET)) pay_patched = video_option_value;
      else if (32'(offset_in_page) == 32'(SCANLINE_OFFSET)) pay_patched = scanline_option_value;
    end
  end

  // decode one request into its result list and next state
  always_comb begin
    n = '0;
    l_kind = '{default: KIND_SEND};
    l_byte = '{default: 8'h00};
    phase_next = phase;
    page_count_next = page_count;
    sector_pos_next = sector_pos;
    offset_in_page_next = offset_in_page;
    held_byte_next = held_byte;
    finished_next = finished;
    if (finished && phase == PH_IDLE) begin
      l_kind[n] = KIND_DONE; n = n + CNT_W'(1);
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (s_tuser == ACT_DATA) begin
            if (sector_pos == '0) begin
              l_kind[n] = KIND_SEND;    l_byte[n] = OP_WRITE_ENABLE; n = n + CNT_W'(1);
              l_kind[n] = KIND_RELEASE; n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = OP_SECTOR_ERASE; n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = addr[23:16];     n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = addr[15:8];      n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = addr[7:0];       n = n + CNT_W'(1);
              l_kind[n] = KIND_RELEASE; n = n + CNT_W'(1);
            end
            offset_in_page_next = '0;
            held_byte_next = s_tdata;
            l_kind[n] = KIND_SEND; l_byte[n] = OP_READ_STATUS; n = n + CNT_W'(1);
            l_kind[n] = KIND_READ; n = n + CNT_W'(1);
            phase_next = PH_PRE;
          end else if (s_tuser == ACT_END) begin
            finished_next = 1'b1;
            l_kind[n] = KIND_DONE; n = n + CNT_W'(1);
          end else begin
            l_kind[n] = KIND_ERROR; n = n + CNT_W'(1);
          end
        end
        PH_PAGE: begin
          if (s_tuser == ACT_DATA) begin
            l_kind[n] = KIND_SEND; l_byte[n] = pay_patched; n = n + CNT_W'(1);
            offset_in_page_next = offset_in_page + OFS_W'(1);
            if (offset_in_page == OFS_W'(PAGE_BYTES - 1)) begin
              l_kind[n] = KIND_RELEASE; n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND; l_byte[n] = OP_READ_STATUS; n = n + CNT_W'(1);
              l_kind[n] = KIND_READ; n = n + CNT_W'(1);
              phase_next = PH_POST;
            end
          end else if (s_tuser == ACT_END) begin
            finished_next = 1'b1;
            offset_in_page_next = '0;
            l_kind[n] = KIND_RELEASE; n = n + CNT_W'(1);
            l_kind[n] = KIND_SEND; l_byte[n] = OP_READ_STATUS; n = n + CNT_W'(1);
            l_kind[n] = KIND_READ; n = n + CNT_W'(1);
            phase_next = PH_POST;
          end else begin
            l_kind[n] = KIND_ERROR; n = n + CNT_W'(1);
          end
        end
        PH_PRE: begin
          if (s_tuser == ACT_STATUS) begin
            if (busy) begin
              l_kind[n] = KIND_READ; n = n + CNT_W'(1);
            end else begin
              l_kind[n] = KIND_RELEASE; n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = OP_WRITE_ENABLE; n = n + CNT_W'(1);
              l_kind[n] = KIND_RELEASE; n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = OP_PAGE_PROGRAM; n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = addr[23:16];     n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = addr[15:8];      n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = addr[7:0];       n = n + CNT_W'(1);
              l_kind[n] = KIND_SEND;    l_byte[n] = held_byte;       n = n + CNT_W'(1);
              offset_in_page_next = OFS_W'(1);
              phase_next = PH_PAGE;
            end
          end else begin
            l_kind[n] = KIND_ERROR; n = n + CNT_W'(1);
          end
        end
        PH_POST: begin
          if (s_tuser == ACT_STATUS) begin
            if (busy) begin
              l_kind[n] = KIND_READ; n = n + CNT_W'(1);
            end else begin
              l_kind[n] = KIND_RELEASE; n = n + CNT_W'(1);
              page_count_next = page_count + 16'd1;
              if (page_count == 16'hFFFF || sector_pos == SEC_W'(SECTOR_PAGES - 1)) begin
                sector_pos_next = '0;
              end else begin
                sector_pos_next = sector_pos + SEC_W'(1);
              end
              offset_in_page_next = '0;
              phase_next = PH_IDLE;
              if (finished) begin
                l_kind[n] = KIND_DONE; n = n + CNT_W'(1);
              end
            end
          end else begin
            l_kind[n] = KIND_ERROR; n = n + CNT_W'(1);
          end
        end
        default: begin
          l_kind[n] = KIND_ERROR; n = n + CNT_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_page <= PATCH_PAGE_RESET;
      video_option_value <= 8'h00;
      scanline_option_value <= 8'h00;
      phase <= PH_IDLE;
      page_count <= '0;
      sector_pos <= '0;
      offset_in_page <= '0;
      held_byte <= '0;
      finished <= 1'b0;
      a_valid <= 1'b0;
      a_cnt <= '0;
      b_rem <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PATCH_PAGE:      patch_page <= cfg_data;
          REG_VIDEO_OPTION:    video_option_value <= cfg_data[7:0];
          REG_SCANLINE_OPTION: scanline_option_value <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_fire) begin
        phase <= phase_next;
        page_count <= page_count_next;
        sector_pos <= sector_pos_next;
        offset_in_page <= offset_in_page_next;
        held_byte <= held_byte_next;
        finished <= finished_next;
      end
      // output list stage
      if (b_free && a_valid) begin
        b_kind <= a_kind;
        b_byte <= a_byte;
        b_rem <= a_cnt;
      end else if (b_free && s_fire) begin
        b_kind <= l_kind;
        b_byte <= l_byte;
        b_rem <= n;
      end else if (m_fire) begin
        for (int i = 0; i < MAX_RESULTS - 1; i++) begin
          b_kind[i] <= b_kind[i+1];
          b_byte[i] <= b_byte[i+1];
        end
        b_rem <= b_rem - CNT_W'(1);
      end
      // skid stage
      if (s_fire && !b_free) begin
        a_kind <= l_kind;
        a_byte <= l_byte;
        a_cnt <= n;
        a_valid <= 1'b1;
      end else if (b_free) begin
        a_valid <= 1'b0;
      end
    end
  end

  a_list_bound: assert property (@(posedge clk) disable iff (rst)
    b_rem <= CNT_W'(MAX_RESULTS))
    else $error("result list longer than its storage");

  a_skid_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (b_rem != '0))
    else $error("skid list held while output list is empty");

  a_skid_nonempty: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !b_free) |=> (a_cnt != '0))
    else $error("request produced an empty result list");

  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !s_fire |=> $stable(phase) && $stable(page_count))
    else $error("sequencer state moved without a request");

endmodule
